@@ rtl/core/rbcs_pkg.sv @@
// Package for the rectangle blitter: frame sizes, operation codes and the
// sequencer state type. No dependencies.
package rbcs_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 24;
    localparam int SIZE_W      = 9;
    localparam int CRD_W       = 10;
    localparam int CRDX_W      = CRD_W + 1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_COPY  = 2'd2,
        OP_SWAP  = 2'd3
    } op_t;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR_SRC,
        S_ADDR_DST,
        S_WRITE,
        S_RD_SRC,
        S_RD_DONE,
        S_RD_DST,
        S_WR_DST,
        S_WR_SRC,
        S_RESULT
    } state_t;

endpackage

@@ rtl/core/rect_blit_copy_swap.sv @@
// Rectangle blitter top level: one frame store memory, one shared address
// unit and the pixel-walk sequencer. Depends on rbcs_pkg.
//
// A pixel write or read uses the address unit, then the frame store; a zero-size
// copy or swap posts its result at once. Copy and swap use the address unit twice
// per pixel pair, read both pixels, write the destination (swap also the source).
// Throughput: one item at a time; the next item is taken once the result is
// in the output register. Reset (rst_n, async low) clears control state and
// sets the image size to 256 x 256; the frame store is not cleared.
module rect_blit_copy_swap
    import rbcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata, low bit up: src_x[9:0], src_y[19:10], rect_w[28:20], rect_h[37:29],
    // dst_x[47:38], dst_y[57:48], pixel_in[81:58], zero pad [87:82]
    input  logic [87:0]          s_tdata,
    // tuser: op[1:0]
    input  logic [1:0]           s_tuser,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: pixel_out[23:0]
    output logic [PIX_W-1:0]     m_tdata,
    // tuser: ok[0]
    output logic                 m_tuser
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_W'(MAX_WIDTH);
            height_reg <= SIZE_W'(MAX_HEIGHT);
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Clamp the size registers to the frame store geometry
    logic [SIZE_W-1:0] eff_w;
    logic [SIZE_W-1:0] eff_h;

    assign eff_w = (width_reg  > SIZE_W'(MAX_WIDTH))  ? SIZE_W'(MAX_WIDTH)  : width_reg;
    assign eff_h = (height_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_reg;

    // ------------------------------------------------------------------
    // Item registers and walk state
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    op_t                 op_reg,  op_next;
    logic [CRD_W-1:0]    sx_reg,  sx_next;
    logic [CRD_W-1:0]    sy_reg,  sy_next;
    logic [CRD_W-1:0]    dx_reg,  dx_next;
    logic [CRD_W-1:0]    dy_reg,  dy_next;
    logic [SIZE_W-1:0]   rw_reg,  rw_next;
    logic [SIZE_W-1:0]   rh_reg,  rh_next;
    logic [PIX_W-1:0]    pin_reg, pin_next;
    logic [SIZE_W-1:0]   xi_reg,  xi_next;   // column offset, outer loop
    logic [SIZE_W-1:0]   yi_reg,  yi_next;   // row offset, inner loop
    logic [ADDR_W-1:0]   sa_reg,  sa_next;
    logic [ADDR_W-1:0]   da_reg,  da_next;
    logic [PIX_W-1:0]    sval_reg, sval_next;
    logic [PIX_W-1:0]    tval_reg, tval_next;
    logic                ok_reg,  ok_next;
    logic [PIX_W-1:0]    res_reg, res_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg,    out_ok_next;
    logic [PIX_W-1:0]    out_pix_reg,   out_pix_next;

    logic                in_xfer;
    logic                out_free;
    logic                empty_rect;
    logic                yi_last;
    logic                xi_last;
    logic                walk_done;

    assign in_xfer    = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign empty_rect = (s_tdata[28:20] == '0) || (s_tdata[37:29] == '0);
    assign yi_last    = (SIZE_W'(yi_reg + 1'b1) == rh_reg);
    assign xi_last    = (SIZE_W'(xi_reg + 1'b1) == rw_reg);
    assign walk_done  = yi_last && xi_last;

    // ------------------------------------------------------------------
    // Shared address unit: bounds check and y*w+x for one coordinate pair
    // ------------------------------------------------------------------
    logic                    sel_dst;
    logic [CRD_W-1:0]        base_x;
    logic [CRD_W-1:0]        base_y;
    logic signed [CRDX_W-1:0] px;
    logic signed [CRDX_W-1:0] py;
    logic                    in_bounds;
    logic [2*SIZE_W-1:0]     row_base;
    logic [ADDR_W-1:0]       pix_addr;

    assign base_x = sel_dst ? dx_reg : sx_reg;
    assign base_y = sel_dst ? dy_reg : sy_reg;
    assign px = $signed({base_x[CRD_W-1], base_x}) + $signed({2'b00, xi_reg});
    assign py = $signed({base_y[CRD_W-1], base_y}) + $signed({2'b00, yi_reg});

    // Coordinates are non-negative below 1023, so the low 10 bits compare directly
    assign in_bounds = !px[CRDX_W-1] && !py[CRDX_W-1]
                    && (px[CRD_W-1:0] < {1'b0, eff_w})
                    && (py[CRD_W-1:0] < {1'b0, eff_h});

    // In bounds, y is below 256, so its low byte carries the row
    assign row_base = (2*SIZE_W)'(py[7:0]) * (2*SIZE_W)'(eff_w);
    assign pix_addr = ADDR_W'(row_base + (2*SIZE_W)'(px[7:0]));

    // ------------------------------------------------------------------
    // Frame store: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  mem [STORE_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [PIX_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [PIX_W-1:0]  rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    // copy or swap of an empty rectangle finishes at once
                    if ((op_t'(s_tuser) == OP_COPY || op_t'(s_tuser) == OP_SWAP)
                        && empty_rect)
                    begin
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_ADDR_SRC;
                    end
                end
            end
            S_ADDR_SRC:
            begin
                if (!in_bounds)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    unique case (op_reg)
                        OP_WRITE: state_next = S_WRITE;
                        OP_READ:  state_next = S_RD_SRC;
                        default:  state_next = S_ADDR_DST;
                    endcase
                end
            end
            S_ADDR_DST:
            begin
                state_next = in_bounds ? S_RD_SRC : S_RESULT;
            end
            S_WRITE:
            begin
                state_next = S_RESULT;
            end
            S_RD_SRC:
            begin
                state_next = (op_reg == OP_READ) ? S_RD_DONE : S_RD_DST;
            end
            S_RD_DONE:
            begin
                state_next = S_RESULT;
            end
            S_RD_DST:
            begin
                state_next = S_WR_DST;
            end
            S_WR_DST:
            begin
                if (op_reg == OP_SWAP)
                begin
                    state_next = S_WR_SRC;
                end
                else
                begin
                    state_next = walk_done ? S_RESULT : S_ADDR_SRC;
                end
            end
            S_WR_SRC:
            begin
                state_next = walk_done ? S_RESULT : S_ADDR_SRC;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs to the address unit and the frame store
    // ------------------------------------------------------------------
    always_comb
    begin
        sel_dst   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = sa_reg;
        mem_wdata = pin_reg;
        mem_re    = 1'b0;
        mem_raddr = sa_reg;
        s_tready  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
            end
            S_ADDR_DST:
            begin
                sel_dst = 1'b1;
            end
            S_WRITE:
            begin
                mem_we = 1'b1;
            end
            S_RD_SRC:
            begin
                mem_re = 1'b1;
            end
            S_RD_DST:
            begin
                mem_re    = 1'b1;
                mem_raddr = da_reg;
            end
            S_WR_DST:
            begin
                mem_we    = 1'b1;
                mem_waddr = da_reg;
                mem_wdata = sval_reg;
            end
            S_WR_SRC:
            begin
                mem_we    = 1'b1;
                mem_wdata = tval_reg;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        op_next        = op_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        rw_next        = rw_reg;
        rh_next        = rh_reg;
        pin_next       = pin_reg;
        xi_next        = xi_reg;
        yi_next        = yi_reg;
        sa_next        = sa_reg;
        da_next        = da_reg;
        sval_next      = sval_reg;
        tval_next      = tval_reg;
        ok_next        = ok_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_pix_next   = out_pix_reg;

        // drop the result once the sink takes it
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    // latch the item and start the walk at the corner
                    op_next  = op_t'(s_tuser);
                    sx_next  = s_tdata[9:0];
                    sy_next  = s_tdata[19:10];
                    rw_next  = s_tdata[28:20];
                    rh_next  = s_tdata[37:29];
                    dx_next  = s_tdata[47:38];
                    dy_next  = s_tdata[57:48];
                    pin_next = s_tdata[81:58];
                    xi_next  = '0;
                    yi_next  = '0;
                    ok_next  = 1'b1;
                    res_next = '0;
                end
            end
            S_ADDR_SRC:
            begin
                sa_next = pix_addr;
                if (!in_bounds)
                begin
                    ok_next = 1'b0;
                end
            end
            S_ADDR_DST:
            begin
                da_next = pix_addr;
                if (!in_bounds)
                begin
                    ok_next = 1'b0;
                end
            end
            S_RD_DONE:
            begin
                res_next = rd_data_reg;
            end
            S_RD_DST:
            begin
                // source pixel arrives while the destination read goes out
                sval_next = rd_data_reg;
            end
            S_WR_DST:
            begin
                tval_next = rd_data_reg;
                if (op_reg != OP_SWAP)
                begin
                    yi_next = yi_last ? '0 : SIZE_W'(yi_reg + 1'b1);
                    xi_next = yi_last ? SIZE_W'(xi_reg + 1'b1) : xi_reg;
                end
            end
            S_WR_SRC:
            begin
                yi_next = yi_last ? '0 : SIZE_W'(yi_reg + 1'b1);
                xi_next = yi_last ? SIZE_W'(xi_reg + 1'b1) : xi_reg;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_pix_next   = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        rw_reg      <= rw_next;
        rh_reg      <= rh_next;
        pin_reg     <= pin_next;
        xi_reg      <= xi_next;
        yi_reg      <= yi_next;
        sa_reg      <= sa_next;
        da_reg      <= da_next;
        sval_reg    <= sval_next;
        tval_reg    <= tval_next;
        ok_reg      <= ok_next;
        res_reg     <= res_next;
        out_ok_reg  <= out_ok_next;
        out_pix_reg <= out_pix_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = out_pix_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != S_IDLE))
        else $error("frame store written while idle");

    a_fail_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("failed operation carries a pixel");

    a_walk_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADDR_DST) |-> ((xi_reg < rw_reg) && (yi_reg < rh_reg)))
        else $error("walk offset outside rectangle");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> !s_tready)
        else $error("second item taken while busy");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for rect_blit_copy_swap: drives pixel and rectangle commands
// and checks every result against a cycle-free predictor of the frame store.
// Depends on rbcs_pkg and the rect_blit_copy_swap RTL only.
module testbench
    import rbcs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One command as it travels on the input stream.
    typedef struct {
        op_t                     op;
        bit signed [CRD_W-1:0]   sx;
        bit signed [CRD_W-1:0]   sy;
        bit [SIZE_W-1:0]         rw;
        bit [SIZE_W-1:0]         rh;
        bit signed [CRD_W-1:0]   dx;
        bit signed [CRD_W-1:0]   dy;
        bit [PIX_W-1:0]          pix;
    } blit_cmd_t;

    typedef struct {
        bit                      ok;
        bit [PIX_W-1:0]          pixel;
    } blit_result_t;

    // Directed row: fixed = 1 means the expected result is typed in the row.
    typedef struct {
        blit_cmd_t               cmd;
        bit                      fixed;
        blit_result_t            want;
    } directed_row_t;

    // Image-size setting for one random phase, with the span that coordinates
    // are drawn from so that most commands land on pixels holding data.
    typedef struct {
        int                      w;
        int                      h;
        int                      span_x;
        int                      span_y;
    } size_phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [SIZE_W-1:0]     cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [87:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [PIX_W-1:0]      m_tdata;
    logic                  m_tuser;

    // Predictor state: a shadow of the frame store, a map of the entries that
    // hold data, and the two size registers as last written.
    bit [PIX_W-1:0]        frame_shadow [STORE_DEPTH];
    bit                    written_map  [STORE_DEPTH];
    bit [SIZE_W-1:0]       width_reg;
    bit [SIZE_W-1:0]       height_reg;

    blit_result_t          pending_results [$];
    blit_result_t          head;

    int                    errors;
    int                    burst_left;
    int                    n_in;
    int                    n_checked;
    int                    n_reads;
    int                    n_rects;
    int                    n_refused;
    int                    n_settings;

    rect_blit_copy_swap u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs; far beyond the slowest legal run.
    initial
    begin
        #30ms;
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Register values above the maximum saturate to the maximum.
    function automatic int active_width();
        return (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
    endfunction

    function automatic int active_height();
        return (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
    endfunction

    // Map (x, y) to a store address; 0 when the pixel lies outside the image.
    function automatic bit locate_pixel(input int x, input int y, output int addr);
        addr = 0;
        if (x < 0 || y < 0 || x >= active_width() || y >= active_height())
            return 1'b0;
        addr = y * active_width() + x;
        return 1'b1;
    endfunction

    // Walk the rectangle column by column (x outer, y inner). Stop at the first
    // pair outside the image. With commit = 0 only report whether the walk would
    // read an entry that never held data (flagged in blank).
    function automatic bit walk_rect(input blit_cmd_t c, input bit commit, output bit blank);
        int             sa;
        int             da;
        bit [PIX_W-1:0] held;
        blank = 1'b0;
        for (int xi = 0; xi < int'(c.rw); xi++)
        begin
            for (int yi = 0; yi < int'(c.rh); yi++)
            begin
                if (!locate_pixel(int'(c.sx) + xi, int'(c.sy) + yi, sa) ||
                    !locate_pixel(int'(c.dx) + xi, int'(c.dy) + yi, da))
                    return 1'b0;
                if (!written_map[sa] || !written_map[da])
                begin
                    blank = 1'b1;
                    return 1'b0;
                end
                if (commit)
                begin
                    held             = frame_shadow[da];
                    frame_shadow[da] = frame_shadow[sa];
                    if (c.op == OP_SWAP)
                        frame_shadow[sa] = held;
                end
            end
        end
        return 1'b1;
    endfunction

    // True if the command would read a store entry that was never written.
    function automatic bit hits_blank(input blit_cmd_t c);
        int addr;
        bit blank;
        case (c.op)
            OP_WRITE: return 1'b0;
            OP_READ:  return locate_pixel(int'(c.sx), int'(c.sy), addr) && !written_map[addr];
            default:
            begin
                void'(walk_rect(c, 1'b0, blank));
                return blank;
            end
        endcase
    endfunction

    // Apply one accepted command to the shadow store and return its result.
    function automatic blit_result_t apply_cmd(input blit_cmd_t c);
        blit_result_t r;
        int           addr;
        bit           blank;
        r.ok    = 1'b0;
        r.pixel = '0;
        case (c.op)
            OP_WRITE:
            begin
                r.ok = locate_pixel(int'(c.sx), int'(c.sy), addr);
                if (r.ok)
                begin
                    frame_shadow[addr] = c.pix;
                    written_map[addr]  = 1'b1;
                end
            end
            OP_READ:
            begin
                r.ok = locate_pixel(int'(c.sx), int'(c.sy), addr);
                if (r.ok)
                    r.pixel = frame_shadow[addr];
            end
            default: r.ok = walk_rect(c, 1'b1, blank);
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic blit_cmd_t make_cmd(input op_t op, input int sx, input int sy,
                                           input int rw, input int rh, input int dx,
                                           input int dy, input int unsigned pix);
        blit_cmd_t c;
        c.op  = op;
        c.sx  = CRD_W'(sx);
        c.sy  = CRD_W'(sy);
        c.rw  = SIZE_W'(rw);
        c.rh  = SIZE_W'(rh);
        c.dx  = CRD_W'(dx);
        c.dy  = CRD_W'(dy);
        c.pix = PIX_W'(pix);
        return c;
    endfunction

    function automatic directed_row_t drow(input blit_cmd_t c, input bit fixed,
                                           input bit ok, input int unsigned pixel);
        directed_row_t r;
        r.cmd        = c;
        r.fixed      = fixed;
        r.want.ok    = ok;
        r.want.pixel = PIX_W'(pixel);
        return r;
    endfunction

    // Mostly on or just past the image, now and then negative or any 10-bit code.
    function automatic int rand_coord(input int span);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 16)
            return $urandom_range(0, span);
        if (pick < 18)
            return -int'($urandom_range(1, 3));
        return int'($urandom_range(0, 1023)) - 512;
    endfunction

    // Mostly tiny rectangles (zero included), a few up to the full range.
    function automatic int rand_size();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return $urandom_range(0, 4);
        if (pick < 9)
            return $urandom_range(1, 16);
        return $urandom_range(0, 256);
    endfunction

    // Draw a command that never reads a blank entry; fall back to a write.
    function automatic blit_cmd_t rand_cmd(input int span_x, input int span_y);
        blit_cmd_t c;
        for (int tries = 0; tries < 30; tries++)
        begin
            c = make_cmd(op_t'($urandom_range(0, 3)),
                         rand_coord(span_x), rand_coord(span_y),
                         rand_size(), rand_size(),
                         rand_coord(span_x), rand_coord(span_y),
                         $urandom_range(0, 24'hFFFFFF));
            if (!hits_blank(c))
                return c;
        end
        c.op = OP_WRITE;
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 30)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Present one command and hold it until the transfer. Bursts of random
    // length alternate with random gaps; long bursts give stretches with no gap.
    // Called and returning at a rising edge.
    task automatic send_item(input blit_cmd_t c, input bit fixed, input blit_result_t fixed_want);
        int           gap;
        blit_result_t want;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.op;
        s_tdata  <= {6'b0, c.pix, c.dy, c.dx, c.rh, c.rw, c.sy, c.sx};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        // Accepted at this edge: advance the predictor in transfer order.
        want = apply_cmd(c);
        pending_results.push_back(fixed ? fixed_want : want);
        burst_left--;
        n_in++;
        if (c.op == OP_READ)
            n_reads++;
        else if (c.op != OP_WRITE)
            n_rects++;
        if (!want.ok)
            n_refused++;
    endtask

    // Drop valid and hold until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write both size registers; only called while the block is idle.
    task automatic program_size(input int w, input int h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= SIZE_W'(w);
        @(posedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= SIZE_W'(h);
        @(posedge clk);
        cfg_we     <= 1'b0;
        width_reg  = SIZE_W'(w);
        height_reg = SIZE_W'(h);
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------

    // Receiver cycles through four moods in turn: always ready, coin flip,
    // mostly stalled, and a regular one-in-five stall.
    initial
    begin : ready_pattern
        int unsigned tick;
        tick = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            case ((tick / 48) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= ((tick % 5) != 0);
            endcase
        end
    end

    // Compare every result transfer with the oldest expectation, field by field.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result with nothing expected: ok=%0b pixel=%06h",
                                          m_tuser, m_tdata));
            else
            begin
                head = pending_results.pop_front();
                n_checked++;
                if (m_tuser !== head.ok)
                    report_mismatch($sformatf("ok got %b want %b", m_tuser, head.ok));
                if (m_tdata !== head.pixel)
                    report_mismatch($sformatf("pixel_out got %06h want %06h",
                                              m_tdata, head.pixel));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        directed_row_t plan [$];
        size_phase_t   phases [$];
        size_phase_t   ph;
        blit_result_t  none;
        blit_cmd_t     c;

        none.ok    = 1'b0;
        none.pixel = '0;
        errors     = 0;
        burst_left = 0;
        n_in       = 0;
        n_checked  = 0;
        n_reads    = 0;
        n_rects    = 0;
        n_refused  = 0;
        n_settings = 0;
        width_reg  = SIZE_W'(MAX_WIDTH);
        height_reg = SIZE_W'(MAX_HEIGHT);

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_WIDTH;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_WRITE;
        m_tready  <= 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill an 8 x 4 image so that store entries 0..31 hold data; every
        // later read, copy and swap stays on entries that were written.
        program_size(8, 4);
        for (int y = 0; y < 4; y++)
            for (int x = 0; x < 8; x++)
                send_item(make_cmd(OP_WRITE, x, y, 0, 0, 0, 0, $urandom_range(0, 24'hFFFFFF)),
                          1'b0, none);

        // Directed rows on the 8 x 4 image.
        plan.push_back(drow(make_cmd(OP_WRITE, 0, 0, 0, 0, 0, 0, 24'hFFFFFF), 1, 1, 0));
        plan.push_back(drow(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1, 1, 24'hFFFFFF));
        plan.push_back(drow(make_cmd(OP_WRITE, 7, 3, 0, 0, 0, 0, 0), 1, 1, 0));
        plan.push_back(drow(make_cmd(OP_READ, 7, 3, 0, 0, 0, 0, 24'hFFFFFF), 1, 1, 0));
        // pixel outside: nothing changes, ok low, zero pixel
        plan.push_back(drow(make_cmd(OP_WRITE, 8, 0, 0, 0, 0, 0, 24'h123456), 1, 0, 0));
        plan.push_back(drow(make_cmd(OP_WRITE, -1, 0, 0, 0, 0, 0, 24'h654321), 1, 0, 0));
        plan.push_back(drow(make_cmd(OP_READ, 0, 4, 0, 0, 0, 0, 0), 1, 0, 0));
        plan.push_back(drow(make_cmd(OP_READ, -512, -512, 0, 0, 0, 0, 0), 1, 0, 0));
        plan.push_back(drow(make_cmd(OP_WRITE, 511, 511, 0, 0, 0, 0, 24'hA5A5A5), 1, 0, 0));
        // zero rectangles: nothing moves, even with corners far outside; then an in-image copy
        plan.push_back(drow(make_cmd(OP_COPY, -512, 511, 0, 5, 511, -512, 0), 1, 1, 0));
        plan.push_back(drow(make_cmd(OP_SWAP, 0, 0, 7, 0, 40, 40, 0), 1, 1, 0));
        plan.push_back(drow(make_cmd(OP_COPY, 0, 0, 2, 2, 4, 2, 0), 1, 1, 0));
        // overlapping copies in both directions follow the column walk
        plan.push_back(drow(make_cmd(OP_COPY, 0, 0, 3, 3, 1, 1, 0), 0, 0, 0));
        plan.push_back(drow(make_cmd(OP_COPY, 2, 1, 3, 3, 0, 0, 0), 0, 0, 0));
        plan.push_back(drow(make_cmd(OP_SWAP, 0, 0, 2, 2, 4, 2, 0), 0, 0, 0));
        plan.push_back(drow(make_cmd(OP_SWAP, 0, 0, 3, 3, 1, 0, 0), 0, 0, 0));
        plan.push_back(drow(make_cmd(OP_SWAP, 5, 1, 2, 2, 5, 1, 0), 0, 0, 0));
        // source or destination runs off the image part way: moved pixels stay
        plan.push_back(drow(make_cmd(OP_COPY, 6, 0, 4, 2, 0, 2, 0), 1, 0, 0));
        plan.push_back(drow(make_cmd(OP_COPY, 0, 0, 2, 2, 7, 3, 0), 1, 0, 0));
        plan.push_back(drow(make_cmd(OP_SWAP, 4, 0, 3, 2, 6, 2, 0), 1, 0, 0));
        // full-range size fails at the first row below the image
        plan.push_back(drow(make_cmd(OP_COPY, 0, 0, 256, 256, 0, 0, 0), 1, 0, 0));
        plan.push_back(drow(make_cmd(OP_SWAP, -1, 0, 2, 2, 4, 0, 0), 1, 0, 0));
        for (int i = 0; i < 6; i++)
            plan.push_back(drow(make_cmd(OP_READ, i, i % 4, 0, 0, 0, 0, 0), 0, 0, 0));

        foreach (plan[i])
            send_item(plan[i].cmd, plan[i].fixed, plan[i].want);

        // Random phases over several image sizes: smallest, register maximum
        // (saturating), zero in either register, odd sizes and the reset size.
        phases.push_back(size_phase_t'{w: 1,   h: 1,   span_x: 2,   span_y: 2});
        phases.push_back(size_phase_t'{w: 511, h: 2,   span_x: 257, span_y: 1});
        phases.push_back(size_phase_t'{w: 0,   h: 32,  span_x: 4,   span_y: 4});
        phases.push_back(size_phase_t'{w: 16,  h: 64,  span_x: 17,  span_y: 3});
        phases.push_back(size_phase_t'{w: 256, h: 4,   span_x: 257, span_y: 1});
        phases.push_back(size_phase_t'{w: 5,   h: 7,   span_x: 6,   span_y: 7});
        phases.push_back(size_phase_t'{w: 32,  h: 0,   span_x: 4,   span_y: 4});
        phases.push_back(size_phase_t'{w: 33,  h: 31,  span_x: 34,  span_y: 2});
        phases.push_back(size_phase_t'{w: 256, h: 256, span_x: 34,  span_y: 1});

        foreach (phases[p])
        begin
            ph = phases[p];
            drain();
            program_size(ph.w, ph.h);
            for (int i = 0; i < 4; i++)
            begin
                c = rand_cmd(ph.span_x, ph.span_y);
                send_item(c, 1'b0, none);
            end
        end

        // Hold until the last result is back, then watch for strays.
        drain();
        repeat (40) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Ran %0d commands (%0d reads, %0d copies/swaps, %0d refused at the edge)",
                 n_in, n_reads, n_rects, n_refused);
        $display("Checked %0d results over %0d image-size settings; %0d mismatches",
                 n_checked, n_settings, errors);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
